@@ design/ows_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ows_pkg;

	localparam int CntW     = 20;
	localparam int RegW     = 10;
	localparam int PullW    = 10;
	localparam int NumRegs  = 8;
	localparam int CfgAddrW = 3;
	localparam int NumMatch = 4;

	// Fixed timing of a read slot and the pullup scale.
	localparam int ReadSampleUs  = 9;
	localparam int ReadReleaseUs = 55;
	localparam int UsPerMs       = 1000;

	typedef logic [CntW-1:0] cnt_t;
	typedef logic [RegW-1:0] cfg_reg_t;
	typedef logic [NumRegs-1:0][RegW-1:0] cfg_t;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_RESET = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_RELEASED = 2'd0,
		MODE_LOW      = 2'd1,
		MODE_HIGH     = 2'd2
	} mode_t;

	// Register indexes on the configuration port.
	localparam logic [CfgAddrW-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_RESET_RELEASE = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_WRITE0_LOW    = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_WRITE0_REL    = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_WRITE1_LOW    = 3'd5;
	localparam logic [CfgAddrW-1:0] REG_WRITE1_REL    = 3'd6;
	localparam logic [CfgAddrW-1:0] REG_READ_LOW      = 3'd7;

	localparam cfg_t CFG_RESET = {
		RegW'(6),   // read low
		RegW'(64),  // write one release
		RegW'(6),   // write one low
		RegW'(10),  // write zero release
		RegW'(60),  // write zero low
		RegW'(410), // reset release
		RegW'(70),  // presence wait
		RegW'(480)  // reset low
	};

	// An input item after the input register; the pullup time is already in microseconds.
	typedef struct packed {
		kind_t kind;
		logic  bit_value;
		cnt_t  pull_us;
		logic  line_level;
	} item_t;

	// Match points of a new slot, lowest index handled first on equal counts.
	typedef struct packed {
		logic [NumMatch-1:0][CntW-1:0] point;
		logic [NumMatch-1:0]           enable;
		logic                          start;
	} plan_t;

	typedef struct packed {
		logic  sample_taken;
		logic  sampled_bit;
		logic  busy;
		mode_t line_mode;
	} result_t;

endpackage

`default_nettype wire

@@ design/ows_slot_plan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ows_slot_plan (
	input  wire ows_pkg::item_t item,
	input  wire ows_pkg::cfg_t  cfg,
	output ows_pkg::plan_t      plan
);
	import ows_pkg::*;

	cnt_t t0, t1, t2, t3;
	cnt_t low_w, rel_w;

	always_comb begin
		low_w = item.bit_value ? CntW'(cfg[REG_WRITE1_LOW]) : CntW'(cfg[REG_WRITE0_LOW]);
		rel_w = item.bit_value ? CntW'(cfg[REG_WRITE1_REL]) : CntW'(cfg[REG_WRITE0_REL]);
		t0 = '0;
		t1 = '0;
		t2 = '0;
		t3 = '0;
		case (item.kind)
			KIND_RESET: begin
				t0 = CntW'(cfg[REG_RESET_LOW]);
				t1 = CntW'(cfg[REG_PRESENCE_WAIT]);
				t3 = CntW'(cfg[REG_RESET_RELEASE]);
			end
			KIND_WRITE: begin
				if (item.pull_us != '0) begin
					// Strong pullup follows the low time directly.
					t2 = low_w;
					t3 = item.pull_us;
				end else begin
					t0 = low_w;
					t3 = rel_w;
				end
			end
			KIND_READ: begin
				t0 = CntW'(cfg[REG_READ_LOW]);
				t1 = CntW'(ReadSampleUs);
				t3 = CntW'(ReadReleaseUs);
			end
			default: begin
			end
		endcase

		plan.point[0] = t0;
		plan.point[1] = t0 + t1;
		plan.point[2] = t0 + t1 + t2;
		plan.point[3] = t0 + t1 + t2 + t3;
		plan.enable   = {1'b1, t2 != '0, t1 != '0, t0 != '0};
		// A command whose final interval is zero is dropped.
		plan.start    = (item.kind != KIND_TICK) && (t3 != '0);
	end

endmodule

`default_nettype wire

@@ design/ows_slot_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ows_slot_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  advance,
	input  wire ows_pkg::item_t  item,
	input  wire ows_pkg::plan_t  plan,
	output ows_pkg::result_t     result
);
	import ows_pkg::*;

	cnt_t                          us_count_q, us_count_d;
	logic [NumMatch-1:0][CntW-1:0] point_q, point_d;
	logic [NumMatch-1:0]           enable_q, enable_d;
	logic                          running_q, running_d;
	mode_t                         mode_q, mode_d;
	logic                          bit_q, bit_d;
	logic                          taken;
	logic [NumMatch-1:0]           hit;

	always_comb begin
		us_count_d = us_count_q;
		point_d    = point_q;
		enable_d   = enable_q;
		running_d  = running_q;
		mode_d     = mode_q;
		bit_d      = bit_q;
		taken      = 1'b0;
		hit        = '0;
		if (plan.start) begin
			us_count_d = '0;
			point_d    = plan.point;
			enable_d   = plan.enable;
			running_d  = 1'b1;
			mode_d     = MODE_LOW;
		end else if (item.kind == KIND_TICK && running_q) begin
			us_count_d = us_count_q + CntW'(1);
			for (int i = 0; i < NumMatch; i++) begin
				hit[i] = enable_q[i] && (us_count_d == point_q[i]);
			end
			// Applied in match order: release, sample, strong high, stop.
			if (hit[0]) begin
				mode_d = MODE_RELEASED;
			end
			if (hit[1]) begin
				bit_d = item.line_level;
				taken = 1'b1;
			end
			if (hit[2]) begin
				mode_d = MODE_HIGH;
			end
			if (hit[3]) begin
				mode_d    = MODE_RELEASED;
				running_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_count_q <= '0;
			point_q    <= '0;
			enable_q   <= '0;
			running_q  <= 1'b0;
			mode_q     <= MODE_RELEASED;
			bit_q      <= 1'b0;
		end else if (advance) begin
			us_count_q <= us_count_d;
			point_q    <= point_d;
			enable_q   <= enable_d;
			running_q  <= running_d;
			mode_q     <= mode_d;
			bit_q      <= bit_d;
		end
	end

	assign result.line_mode    = mode_d;
	assign result.busy         = running_d;
	assign result.sampled_bit  = bit_d;
	assign result.sample_taken = taken;

endmodule

`default_nettype wire

@@ design/one_wire_slot_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Time slot generator for a one-wire bus master, counting in microseconds.
// Every input item yields exactly one result item. A tick item advances the
// slot counter by one microsecond while a slot runs; a reset, write or read
// command starts a new slot (abandoning any running one), drives the line
// low and restarts the counter, unless its final interval is zero, in which
// case it changes nothing. Each slot walks through up to four match points:
// release, sample of the line level, strong pullup, and final release that
// ends the slot. The design takes one item per clock while the output side
// is not stalled: items pass through an input register, slot planning and
// match compare against the state registers, and an output register, where a
// result item is held until the output side takes it. The input side stays
// ready while the output register can drain in the same cycle.
// The eight timing registers are written through the configuration port and
// must only be changed while no items are in flight.

module one_wire_slot_timer (
	input  wire                             clk,
	input  wire                             arst_n,
	// Configuration write port.
	input  wire                             cfg_we,
	input  wire  [ows_pkg::CfgAddrW-1:0]    cfg_addr,
	input  wire  [ows_pkg::RegW-1:0]        cfg_wdata,
	// Input items.
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [15:0]                     s_tdata,  // bit_value, pullup_ms[9:0], line_level
	input  wire  [1:0]                      s_tuser,  // kind
	// Result items.
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [7:0]                      m_tdata   // line_mode[1:0], busy_res, sampled_bit,
	                                                  // sample_taken
);
	import ows_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	plan_t   plan;
	result_t result;
	result_t result_q;
	cnt_t    pull_us;

	// Timing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q[cfg_addr] <= cfg_wdata;
		end
	end

	// The item moves into the state stage whenever the result register is free
	// or is being emptied in this cycle.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// The millisecond-to-microsecond scaling is done ahead of the input register
	// so the state stage only sees adds and compares.
	assign pull_us = CntW'(s_tdata[PullW:1] * UsPerMs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind       <= kind_t'(s_tuser);
			item_s1.bit_value  <= s_tdata[0];
			item_s1.pull_us    <= pull_us;
			item_s1.line_level <= s_tdata[PullW+1];
		end
	end

	ows_slot_plan u_plan (
		.item (item_s1),
		.cfg  (cfg_q),
		.plan (plan)
	);

	ows_slot_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.plan    (plan),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tdata = {3'b000, result_q.sample_taken, result_q.sampled_bit, result_q.busy,
		result_q.line_mode};

endmodule

`default_nettype wire

@@ bench/one_wire_slot_timer_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the one-wire slot timer. Items go in on the
// slave-side stream and every accepted item is run through a behavioral
// copy of the slot logic kept here. That copy holds its own counter, match
// points and timing registers. Each result item that leaves the master side
// is compared field by field with the oldest expected result still waiting.

module one_wire_slot_timer_tb;
	import ows_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = '0;
	logic [RegW-1:0]     cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata = '0;  // bit_value, pullup_ms[9:0], line_level
	logic [1:0]          s_tuser = '0;  // kind
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;       // line_mode[1:0], busy_res, sampled_bit, sample_taken

	one_wire_slot_timer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// Behavioral copy of the slot state, advanced once per accepted item.
	logic [RegW-1:0] timing_regs [NumRegs];
	cnt_t            us_now = '0;
	cnt_t            marks [NumMatch];
	logic [3:0]      marks_on = '0;
	bit              slot_live = 1'b0;
	mode_t           drive_now = MODE_RELEASED;
	bit              held_bit = 1'b0;

	result_t pending_results [$];
	result_t got_res;
	result_t want_res;
	int      errors = 0;
	int      items_sent = 0;
	int      src_idle = 25;  // percent of cycles the sender holds back
	int      sink_stall = 64; // percent of cycles the receiver stalls

	initial begin
		for (int i = 0; i < NumRegs; i++) begin
			timing_regs[i] = CFG_RESET[i];
		end
		for (int i = 0; i < NumMatch; i++) begin
			marks[i] = '0;
		end
	end

	// Start a slot from four intervals. The match points are cumulative, and
	// a zero interval disables its match. A zero final interval means the
	// command is dropped and whatever slot is running carries on.
	function automatic void open_slot(int t0, int t1, int t2, int t3);
		int acc;
		if (t3 == 0) begin
			return;
		end
		acc = t0;
		marks[0] = CntW'(acc);
		acc += t1;
		marks[1] = CntW'(acc);
		acc += t2;
		marks[2] = CntW'(acc);
		acc += t3;
		marks[3] = CntW'(acc);
		marks_on = {1'b1, t2 != 0, t1 != 0, t0 != 0};
		us_now = '0;
		drive_now = MODE_LOW;
		slot_live = 1'b1;
	endfunction

	// Apply one item to the slot state and return the result it yields.
	function automatic result_t advance_slot(kind_t k, bit b, logic [PullW-1:0] p, bit lvl);
		result_t         r;
		bit              took;
		logic [RegW-1:0] low_t;
		took = 1'b0;
		case (k)
			KIND_TICK: begin
				if (slot_live) begin
					us_now = us_now + 1'b1;
					// Release, sample, strong high, end: in this order on equal counts.
					if (marks_on[0] && us_now == marks[0]) begin
						drive_now = MODE_RELEASED;
					end
					if (marks_on[1] && us_now == marks[1]) begin
						held_bit = lvl;
						took = 1'b1;
					end
					if (marks_on[2] && us_now == marks[2]) begin
						drive_now = MODE_HIGH;
					end
					if (marks_on[3] && us_now == marks[3]) begin
						drive_now = MODE_RELEASED;
						slot_live = 1'b0;
					end
				end
			end
			KIND_RESET: begin
				open_slot(timing_regs[REG_RESET_LOW], timing_regs[REG_PRESENCE_WAIT], 0,
					timing_regs[REG_RESET_RELEASE]);
			end
			KIND_WRITE: begin
				low_t = b ? timing_regs[REG_WRITE1_LOW] : timing_regs[REG_WRITE0_LOW];
				// With a strong pullup the low time moves to the high match and
				// the pullup time becomes the final interval.
				if (p != 0) begin
					open_slot(0, 0, low_t, p * UsPerMs);
				end else begin
					open_slot(low_t, 0, 0,
						b ? timing_regs[REG_WRITE1_REL] : timing_regs[REG_WRITE0_REL]);
				end
			end
			default: begin
				open_slot(timing_regs[REG_READ_LOW], ReadSampleUs, 0, ReadReleaseUs);
			end
		endcase
		r.line_mode = drive_now;
		r.busy = slot_live;
		r.sampled_bit = held_bit;
		r.sample_taken = took;
		return r;
	endfunction

	// Ticks a command needs to run its slot to the end; zero when it is dropped.
	function automatic int slot_span(kind_t k, bit b, logic [PullW-1:0] p);
		int low_t;
		int rel_t;
		low_t = b ? timing_regs[REG_WRITE1_LOW] : timing_regs[REG_WRITE0_LOW];
		rel_t = b ? timing_regs[REG_WRITE1_REL] : timing_regs[REG_WRITE0_REL];
		case (k)
			KIND_RESET: begin
				if (timing_regs[REG_RESET_RELEASE] == 0) begin
					return 0;
				end
				return timing_regs[REG_RESET_LOW] + timing_regs[REG_PRESENCE_WAIT] +
					timing_regs[REG_RESET_RELEASE];
			end
			KIND_WRITE: begin
				if (p != 0) begin
					return low_t + p * UsPerMs;
				end
				return (rel_t == 0) ? 0 : low_t + rel_t;
			end
			KIND_READ: begin
				return timing_regs[REG_READ_LOW] + ReadSampleUs + ReadReleaseUs;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (errors < 40) begin
			$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
		end
		errors++;
	endtask

	// Offer one item, idling at random first. The caller is at a rising edge,
	// and the item counts as accepted at the edge where s_tready is seen high.
	// A row with a hand-written expectation pushes that instead of the prediction,
	// but the slot state is advanced either way.
	task automatic send_item(kind_t k, bit b, logic [PullW-1:0] p, bit lvl, bit typed,
		result_t want);
		result_t predicted;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {4'b0, lvl, p, b};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predicted = advance_slot(k, b, p, lvl);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// Tick items with random line levels; the unused fields are random too.
	task automatic tick_burst(int n);
		for (int i = 0; i < n; i++) begin
			send_item(KIND_TICK, 1'($urandom_range(1)), PullW'($urandom_range(1023)),
				1'($urandom_range(1)), 1'b0, '0);
		end
	endtask

	// Let the pipeline run dry before touching the timing registers.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write of a batch.
	task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [RegW-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		timing_regs[addr] = value;
		@(posedge clk);
	endtask

	// Output side: compare each result item, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result item with nothing expected", m_tdata, 0);
			end else begin
				want_res = pending_results.pop_front();
				got_res = result_t'(m_tdata[4:0]);
				if (got_res.line_mode !== want_res.line_mode) begin
					report_mismatch("line_mode", got_res.line_mode, want_res.line_mode);
				end
				if (got_res.busy !== want_res.busy) begin
					report_mismatch("busy_res", got_res.busy, want_res.busy);
				end
				if (got_res.sampled_bit !== want_res.sampled_bit) begin
					report_mismatch("sampled_bit", got_res.sampled_bit, want_res.sampled_bit);
				end
				if (got_res.sample_taken !== want_res.sample_taken) begin
					report_mismatch("sample_taken", got_res.sample_taken,
						want_res.sample_taken);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_stall);
	end

	// Directed rows. A configuration row writes one register while nothing is
	// in flight; an item row either carries its expectation or leaves it to
	// the predictor. Columns: is_cfg, addr, value, kind, bit_value, pullup_ms,
	// line_level, typed, expectation {sample_taken, sampled_bit, busy, line_mode}.
	typedef struct packed {
		bit                  is_cfg;
		logic [CfgAddrW-1:0] addr;
		logic [RegW-1:0]     value;
		kind_t               kind;
		bit                  bit_value;
		logic [PullW-1:0]    pull_ms;
		bit                  level;
		bit                  typed;
		result_t             want;
	} script_row_t;

	localparam result_t NoCheck = '0;
	localparam int ScriptLen = 27;

	script_row_t script [ScriptLen] = '{
		// Tick while idle right after reset changes nothing.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b1,
			'{1'b0, 1'b0, 1'b0, MODE_RELEASED}},
		// A read at the reset timing drives low and starts the counter.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_READ, 1'b0, 10'd0, 1'b0, 1'b1,
			'{1'b0, 1'b0, 1'b1, MODE_LOW}},
		// Short timing so that whole slots fit in a few ticks. A zero write-zero
		// recovery makes that command a no-op, and a zero write-one low time
		// leaves the release match disabled.
		'{1'b1, REG_RESET_LOW,     10'd1, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b1, REG_PRESENCE_WAIT, 10'd1, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b1, REG_RESET_RELEASE, 10'd1, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b1, REG_WRITE0_LOW,    10'd2, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b1, REG_WRITE0_REL,    10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b1, REG_WRITE1_LOW,    10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b1, REG_WRITE1_REL,    10'd2, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b1, REG_READ_LOW,      10'd1, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		// The read from the default timing is still running.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b1, 1'b0, NoCheck},
		// A reset pulse abandons it; nothing has been sampled yet.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_RESET, 1'b1, 10'd1023, 1'b1, 1'b1,
			'{1'b0, 1'b0, 1'b1, MODE_LOW}},
		// Release, presence sample of a high line, end of slot.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b1, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		// Write zero with a zero recovery time is dropped entirely.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_WRITE, 1'b0, 10'd0, 1'b0, 1'b1,
			'{1'b0, 1'b1, 1'b0, MODE_RELEASED}},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		// Write one: low stays until the final release.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_WRITE, 1'b1, 10'd0, 1'b1, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b1, 1'b0, NoCheck},
		// Write zero with the longest pullup goes strong high after its low time.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_WRITE, 1'b0, 10'd1023, 1'b0, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		// A read cuts the pullup short.
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_READ, 1'b1, 10'd512, 1'b1, 1'b0, NoCheck},
		// With no reset release time a reset pulse is ignored and the read goes on.
		'{1'b1, REG_RESET_RELEASE, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_RESET, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck},
		'{1'b0, REG_RESET_LOW, 10'd0, KIND_TICK, 1'b0, 10'd0, 1'b0, 1'b0, NoCheck}
	};

	initial begin
		int               stop_at;
		int               span;
		int               n;
		kind_t            k;
		bit               b;
		logic [PullW-1:0] p;
		logic [RegW-1:0]  v;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ScriptLen; i++) begin
			if (script[i].is_cfg) begin
				if (i == 0 || !script[i-1].is_cfg) begin
					settle();
				end
				write_reg(script[i].addr, script[i].value);
				if (i == ScriptLen - 1 || !script[i+1].is_cfg) begin
					cfg_we <= 1'b0;
				end
			end else begin
				send_item(script[i].kind, script[i].bit_value, script[i].pull_ms,
					script[i].level, script[i].typed, script[i].want);
			end
		end

		// Random phases. The first two idle the sender a quarter of the time and
		// stall the receiver most of it, the next two swap that, the last two run
		// flat out. Timing goes from all zero to all maximum to mixed sets.
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			src_idle = (phase < 2) ? 25 : (phase < 4) ? 64 : 0;
			sink_stall = (phase < 2) ? 64 : (phase < 4) ? 25 : 0;
			for (int r = 0; r < NumRegs; r++) begin
				case (phase)
					0: v = '0;
					1: v = '1;
					default: begin
						n = $urandom_range(9);
						v = (n == 0) ? RegW'(0) : (n == 1) ? RegW'(1023) :
							RegW'($urandom_range(1, 12));
					end
				endcase
				write_reg(CfgAddrW'(r), v);
			end
			cfg_we <= 1'b0;

			stop_at = items_sent + 140;
			while (items_sent < stop_at) begin
				if ($urandom_range(9) == 0) begin
					// Noise: any kind with any fields, no attention to slot state.
					n = $urandom_range(1, 6);
					for (int j = 0; j < n; j++) begin
						send_item(kind_t'($urandom_range(3)), 1'($urandom_range(1)),
							PullW'($urandom_range(1023)), 1'($urandom_range(1)), 1'b0, '0);
					end
				end else begin
					// A command followed by ticks that mostly carry it to its end and
					// sometimes stop short, so the next command abandons it.
					k = kind_t'($urandom_range(1, 3));
					b = 1'($urandom_range(1));
					p = (k == KIND_WRITE && $urandom_range(5) == 0) ?
						PullW'($urandom_range(1, 1023)) : '0;
					span = slot_span(k, b, p);
					send_item(k, b, p, 1'($urandom_range(1)), 1'b0, '0);
					if (span != 0 && span <= 150 && $urandom_range(3) != 0) begin
						tick_burst(span + $urandom_range(3));
					end else begin
						tick_burst($urandom_range(20));
					end
				end
			end

			// One pullup run to its end: a millisecond of strong high.
			if (phase == 5) begin
				b = 1'($urandom_range(1));
				span = slot_span(KIND_WRITE, b, 10'd1);
				send_item(KIND_WRITE, b, 10'd1, 1'($urandom_range(1)), 1'b0, '0);
				tick_burst(span + 3);
			end
		end

		settle();
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
